>>> sv/trle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trle_pkg
// Shared constants, types and controller/datapath interface structs for the
// transparent run-length encoder.
// ----------------------------------------------------------------------------
package trle_pkg;

  localparam int MAX_RUN   = 60;
  localparam int PIX_W     = 8;
  localparam int DIM_W     = 12;
  localparam int RUN_W     = 7;
  localparam int BUF_AW    = $clog2(MAX_RUN);
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd1;

  localparam logic [PIX_W-1:0] ROW_END_CODE = 8'h80;
  localparam logic [PIX_W-1:0] TRANS_FLAG   = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE_HDR,
    ST_PRE_LIT,
    ST_PUSH,
    ST_POST_HDR,
    ST_POST_LIT,
    ST_ROW_END
  } state_t;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_HDR,
    EM_LIT,
    EM_ROW_END
  } emit_t;

  typedef struct packed {
    logic  accept;
    logic  push;
    logic  clear_run;
    logic  lit_step;
    emit_t emit;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic pre_close;
    logic row_end;
    logic kind;
    logic run_trans;
    logic lit_last;
    logic slot_free;
  } status_t;

endpackage

>>> sv/trle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trle_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module trle_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/trle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trle_ctrl
// Controller state machine: accepts pixels, sequences run closes, literal
// drains and row-end bytes, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module trle_ctrl
  import trle_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd.accept    = 1'b0;
    cmd.push      = 1'b0;
    cmd.clear_run = 1'b0;
    cmd.lit_step  = 1'b0;
    cmd.emit      = EM_NONE;
    cmd.last      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.pre_close ? ST_PRE_HDR : ST_PUSH;
        end
      end
      ST_PRE_HDR: begin
        if (sts.slot_free) begin
          cmd.emit = EM_HDR;
          if (sts.run_trans) begin
            cmd.last      = !sts.row_end;
            cmd.clear_run = 1'b1;
            state_nxt     = ST_PUSH;
          end else begin
            state_nxt = ST_PRE_LIT;
          end
        end
      end
      ST_PRE_LIT: begin
        if (sts.slot_free) begin
          cmd.emit = EM_LIT;
          if (sts.lit_last) begin
            cmd.last      = !sts.row_end;
            cmd.clear_run = 1'b1;
            state_nxt     = ST_PUSH;
          end else begin
            cmd.lit_step = 1'b1;
          end
        end
      end
      ST_PUSH: begin
        cmd.push = 1'b1;
        if (sts.row_end) begin
          if (sts.kind) begin
            cmd.clear_run = 1'b1;
            state_nxt     = ST_ROW_END;
          end else begin
            state_nxt = ST_POST_HDR;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POST_HDR: begin
        if (sts.slot_free) begin
          cmd.emit  = EM_HDR;
          state_nxt = ST_POST_LIT;
        end
      end
      ST_POST_LIT: begin
        if (sts.slot_free) begin
          cmd.emit = EM_LIT;
          if (sts.lit_last) begin
            cmd.clear_run = 1'b1;
            state_nxt     = ST_ROW_END;
          end else begin
            cmd.lit_step = 1'b1;
          end
        end
      end
      ST_ROW_END: begin
        if (sts.slot_free) begin
          cmd.emit  = EM_ROW_END;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/trle_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trle_dp
// Datapath: configuration registers, row and column counters, open run
// state, literal buffer RAM and the output register.
// ----------------------------------------------------------------------------
module trle_dp
  import trle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [PIX_W-1:0]     in_pixel,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  cmd_t                 cmd,
  output status_t              sts,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [PIX_W-1:0]     out_code,
  output logic                 out_last,
  output logic                 out_image_end
);

  logic [DIM_W-1:0]  row_width_r;
  logic [DIM_W-1:0]  row_count_r;
  logic [DIM_W-1:0]  col_r;
  logic [DIM_W-1:0]  row_r;
  logic [RUN_W-1:0]  run_len_r;
  logic [RUN_W-1:0]  run_len_nxt;
  logic              run_trans_r;
  logic              run_trans_nxt;
  logic [BUF_AW-1:0] lit_idx_r;
  logic [BUF_AW-1:0] lit_idx_nxt;
  logic [PIX_W-1:0]  pix_r;
  logic              kind_r;
  logic              row_end_r;
  logic              last_row_r;
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_code_r;
  logic              out_last_r;
  logic              out_user_r;

  logic              kind_in;
  logic [DIM_W-1:0]  col_plus;
  logic [DIM_W-1:0]  row_plus;
  logic              row_end_in;
  logic              last_row_in;
  logic              run_full;
  logic              buf_wr_en;
  logic [PIX_W-1:0]  buf_rd_data;
  logic [PIX_W-1:0]  hdr_code;
  logic [PIX_W-1:0]  emit_code;
  logic              slot_free;

  assign kind_in     = (in_pixel == '0);
  assign col_plus    = col_r + 1'b1;
  assign row_plus    = row_r + 1'b1;
  assign row_end_in  = (col_plus >= row_width_r);
  assign last_row_in = (row_plus >= row_count_r);
  assign run_full    = (run_len_r >= RUN_W'(MAX_RUN));
  assign slot_free   = !out_valid_r || out_tready;

  assign sts.pre_close = (run_len_r != '0) && ((kind_in != run_trans_r) || run_full);
  assign sts.row_end   = row_end_r;
  assign sts.kind      = kind_r;
  assign sts.run_trans = run_trans_r;
  assign sts.lit_last  = ({1'b0, lit_idx_r} + 1'b1) == run_len_r;
  assign sts.slot_free = slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= DIM_W'(1);
      row_count_r <= DIM_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROW_WIDTH: row_width_r <= cfg_data;
        CFG_ROW_COUNT: row_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.accept) begin
      col_r <= row_end_in ? '0 : col_plus;
      if (row_end_in) begin
        row_r <= last_row_in ? '0 : row_plus;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r     <= in_pixel;
      kind_r    <= kind_in;
      row_end_r <= row_end_in;
      if (row_end_in) begin
        last_row_r <= last_row_in;
      end
    end
  end

  always_comb begin
    run_len_nxt   = run_len_r;
    run_trans_nxt = run_trans_r;
    if (cmd.clear_run) begin
      run_len_nxt = '0;
    end else if (cmd.push) begin
      if (run_len_r == '0) begin
        run_trans_nxt = kind_r;
      end
      if (!run_full) begin
        run_len_nxt = run_len_r + 1'b1;
      end
    end
  end

  always_comb begin
    if (cmd.clear_run) begin
      lit_idx_nxt = '0;
    end else if (cmd.lit_step) begin
      lit_idx_nxt = lit_idx_r + 1'b1;
    end else begin
      lit_idx_nxt = lit_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_len_r   <= '0;
      run_trans_r <= 1'b0;
      lit_idx_r   <= '0;
    end else begin
      run_len_r   <= run_len_nxt;
      run_trans_r <= run_trans_nxt;
      lit_idx_r   <= lit_idx_nxt;
    end
  end

  assign buf_wr_en = cmd.push && !cmd.clear_run && !kind_r && !run_full;

  trle_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_RUN)
  ) u_buf (
    .clk     (clk),
    .wr_en   (buf_wr_en),
    .wr_addr (run_len_r[BUF_AW-1:0]),
    .wr_data (pix_r),
    .rd_addr (lit_idx_nxt),
    .rd_data (buf_rd_data)
  );

  assign hdr_code = run_trans_r ? (TRANS_FLAG | PIX_W'(run_len_r)) : PIX_W'(run_len_r);

  always_comb begin
    unique case (cmd.emit)
      EM_HDR:     emit_code = hdr_code;
      EM_LIT:     emit_code = buf_rd_data;
      EM_ROW_END: emit_code = ROW_END_CODE;
      default:    emit_code = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit != EM_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EM_NONE) begin
      out_code_r <= emit_code;
      out_last_r <= cmd.last;
      out_user_r <= (cmd.emit == EM_ROW_END) && last_row_r;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_code      = out_code_r;
  assign out_last      = out_last_r;
  assign out_image_end = out_user_r;

endmodule

>>> sv/transparent_run_length_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transparent_run_length_encoder
// Encodes rows of 8-bit palette pixels into transparent/opaque run codes.
// ----------------------------------------------------------------------------
// A pixel that causes no output is accepted in ST_IDLE and then extends the
// open run in ST_PUSH. Run headers, literal bytes drained from the literal
// buffer RAM and row-end bytes leave through one output register one transfer
// at a time, and each waits while the output side stalls. A pixel that closes
// an opaque run first sends its header and then its literal bytes, and no new
// pixel is taken until that is through. Rows are closed with 0x80, which
// carries the image-end flag on the final row.
// ----------------------------------------------------------------------------
module transparent_run_length_encoder
  import trle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] pixel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] code_byte
  output logic                 out_tlast,
  output logic                 out_tuser,  // [0] image_end
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  trle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  trle_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_pixel      (in_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_code      (out_tdata),
    .out_last      (out_tlast),
    .out_image_end (out_tuser)
  );

endmodule
